>>> rtl/rbe_pkg.sv
// shared types and constants of the rle byte encoder
`default_nettype none

package rbe_pkg;

    localparam int unsigned CNT_W          = 7;
    localparam int unsigned BYTES_PER_WORD = 8;
    localparam int unsigned WORD_W         = 64;
    localparam int unsigned BCNT_W         = 4;
    localparam int unsigned RESULT_LIMIT   = 16;
    localparam int unsigned NRES_W         = 5;

    localparam logic [7:0] RUN_FLAG = 8'h80;

    // one work step for the back end, carried out in field order:
    // store write, run packet, literal packet, step close
    typedef struct packed {
        logic             push;
        logic             run;
        logic             flush;
        logic             step_end;
        logic             blk_end;
        logic [7:0]       data;
        logic [CNT_W-1:0] idx;
        logic [CNT_W-1:0] run_len;
        logic [CNT_W-1:0] flush_len;
    } t_cmd;

    typedef struct packed {
        logic [WORD_W-1:0] packed_bytes;
        logic [BCNT_W-1:0] byte_count;
        logic              last_of_run;
        logic              block_done;
    } t_word;

endpackage

`default_nettype wire

>>> rtl/rbe_fifo.sv
// small register-based first-in first-out queue
`default_nettype none

module rbe_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr_valid,
    output logic                  o_wr_ready,
    input  wire logic [WIDTH-1:0] i_wr_data,
    output logic                  o_rd_valid,
    input  wire logic             i_rd_ready,
    output logic [WIDTH-1:0]      o_rd_data
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, n_wp;
    logic [PW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             w_wr, w_rd;

    assign o_wr_ready = (r_cnt != CW'(DEPTH));
    assign o_rd_valid = (r_cnt != '0);
    assign o_rd_data  = r_mem[r_rp];
    assign w_wr       = i_wr_valid && o_wr_ready;
    assign w_rd       = o_rd_valid && i_rd_ready;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_wr) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (w_rd) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/rbe_front.sv
// front end: takes raw bytes, classifies runs and literals, issues commands
`default_nettype none

module rbe_front #(
    parameter int unsigned MAX_PACKET = 127
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire logic [7:0]   i_data_byte,
    input  wire logic         i_block_end,
    output logic              o_cmd_valid,
    input  wire logic         i_cmd_ready,
    output rbe_pkg::t_cmd     o_cmd
);

    localparam int unsigned CW = rbe_pkg::CNT_W;
    localparam logic [CW-1:0] MAX_C  = CW'(MAX_PACKET);
    localparam logic [CW-1:0] MAX_M1 = CW'(MAX_PACKET - 1);

    typedef struct packed {
        logic          in_lit;
        logic [CW-1:0] run_extra;
        logic [CW-1:0] lit_cnt;
    } t_scan;

    typedef struct packed {
        t_scan         st;
        rbe_pkg::t_cmd cmd;
    } t_take;

    // classify byte c, given whether it equals the byte after it
    function automatic t_take take_byte(input t_scan st, input logic [7:0] c, input logic eq);
        t_take r;
        r          = '0;
        r.st       = st;
        r.cmd.data = c;
        if (!st.in_lit) begin
            if (eq && (st.run_extra < MAX_M1)) begin
                r.st.run_extra = st.run_extra + 1'b1;
                return r;
            end
            if (st.run_extra != '0) begin
                r.cmd.run      = 1'b1;
                r.cmd.run_len  = st.run_extra + 1'b1;
                r.st.in_lit    = 1'b1;
                r.st.run_extra = '0;
                r.st.lit_cnt   = '0;
                return r;
            end
            r.st.in_lit  = 1'b1;
            r.st.lit_cnt = '0;
        end
        if (eq) begin
            // a run starts here: close the literal, possibly empty
            r.cmd.flush     = 1'b1;
            r.cmd.flush_len = r.st.lit_cnt;
            r.st.in_lit     = 1'b0;
            r.st.run_extra  = CW'(1);
            r.st.lit_cnt    = '0;
            return r;
        end
        if (r.st.lit_cnt < MAX_C) begin
            r.cmd.push   = 1'b1;
            r.cmd.idx    = r.st.lit_cnt;
            r.st.lit_cnt = r.st.lit_cnt + 1'b1;
        end
        if (r.st.lit_cnt >= MAX_C) begin
            r.cmd.flush     = 1'b1;
            r.cmd.flush_len = r.st.lit_cnt;
            r.st            = '0;
        end
        return r;
    endfunction

    t_scan      r_scan;
    logic [7:0] r_held_byte;
    logic       r_held_v;
    logic       r_busy;
    logic [7:0] r_end_byte;

    t_take      w_held;
    t_take      w_first;
    t_take      w_last;
    logic       w_accept;

    assign o_in_ready = !r_busy && i_cmd_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        w_held  = take_byte(r_scan, r_held_byte, r_held_byte == i_data_byte);
        w_first = '0;
        if (r_held_v) begin
            w_first = w_held;
        end else begin
            w_first.st = r_scan;
        end

        // final byte counts as unequal to its successor, then everything flushes
        w_last = take_byte(r_scan, r_end_byte, 1'b0);
        if (w_last.st.in_lit) begin
            w_last.cmd.flush     = 1'b1;
            w_last.cmd.flush_len = w_last.st.lit_cnt;
        end
        w_last.cmd.step_end = 1'b1;
        w_last.cmd.blk_end  = 1'b1;

        if (r_busy) begin
            o_cmd_valid = 1'b1;
            o_cmd       = w_last.cmd;
        end else begin
            o_cmd_valid       = w_accept && (!i_block_end || r_held_v);
            o_cmd             = w_first.cmd;
            o_cmd.step_end    = !i_block_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan      <= '0;
            r_held_byte <= '0;
            r_held_v    <= 1'b0;
            r_busy      <= 1'b0;
        end else if (r_busy) begin
            if (i_cmd_ready) begin
                r_scan <= '0;
                r_busy <= 1'b0;
            end
        end else if (w_accept) begin
            r_scan <= w_first.st;
            if (i_block_end) begin
                r_held_byte <= '0;
                r_held_v    <= 1'b0;
                r_busy      <= 1'b1;
            end else begin
                r_held_byte <= i_data_byte;
                r_held_v    <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_end_byte <= i_data_byte;
        end
    end

    a_scan_counts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_scan.in_lit |-> (r_scan.lit_cnt < MAX_C && r_scan.run_extra == '0)) and
        (!r_scan.in_lit |-> (r_scan.lit_cnt == '0 && r_scan.run_extra < MAX_C)))
        else $error("scan counters out of range");

    a_end_clears_held : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_block_end) |=> (r_busy && !r_held_v))
        else $error("block end did not enter the flush phase");

endmodule

`default_nettype wire

>>> rtl/rbe_back.sv
// back end: carries out commands, holds the literal store, packs output words
`default_nettype none

module rbe_back #(
    parameter int unsigned MAX_PACKET = 127
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_ready,
    input  wire rbe_pkg::t_cmd i_cmd,
    output logic               o_word_valid,
    input  wire logic          i_word_ready,
    output rbe_pkg::t_word     o_word
);

    localparam int unsigned CW = rbe_pkg::CNT_W;
    localparam int unsigned AW = $clog2(MAX_PACKET);
    localparam int unsigned NW = rbe_pkg::NRES_W;
    localparam int unsigned BW = rbe_pkg::BCNT_W;
    localparam int unsigned WW = rbe_pkg::WORD_W;

    localparam logic [NW-1:0] LIMIT    = NW'(rbe_pkg::RESULT_LIMIT);
    localparam logic [NW-1:0] LIMIT_M1 = NW'(rbe_pkg::RESULT_LIMIT - 1);
    localparam logic [BW-1:0] PK_FULL  = BW'(rbe_pkg::BYTES_PER_WORD);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RUN_H = 3'd1;
    localparam logic [2:0] S_RUN_B = 3'd2;
    localparam logic [2:0] S_LIT_H = 3'd3;
    localparam logic [2:0] S_LIT_D = 3'd4;
    localparam logic [2:0] S_END   = 3'd5;

    logic [2:0]     r_state, n_state;
    rbe_pkg::t_cmd  r_cmd, n_cmd;
    logic [WW-1:0]  r_pk_data, n_pk_data;
    logic [BW-1:0]  r_pk_cnt, n_pk_cnt;
    logic [WW-1:0]  r_carry_data, n_carry_data;
    logic [BW-1:0]  r_carry_cnt, n_carry_cnt;
    logic           r_carry_v, n_carry_v;
    logic [NW-1:0]  r_nres, n_nres;
    logic [CW-1:0]  r_lidx, n_lidx;

    logic [7:0]     r_mem [MAX_PACKET];
    logic [7:0]     r_rd_data;

    logic           w_byte_v;
    logic [7:0]     w_byte;
    logic           w_adv;
    logic           w_rd_en;
    logic [CW-1:0]  w_rd_addr;
    logic           w_wr_en;
    logic [2:0]     w_after_run;
    logic [2:0]     w_after_lit;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign w_wr_en     = o_cmd_ready && i_cmd_valid && i_cmd.push;

    assign w_after_lit = r_cmd.step_end ? S_END : S_IDLE;
    assign w_after_run = r_cmd.flush ? S_LIT_H : w_after_lit;

    always_comb begin
        unique case (r_state)
            S_RUN_H: w_byte = rbe_pkg::RUN_FLAG | {1'b0, r_cmd.run_len};
            S_RUN_B: w_byte = r_cmd.data;
            S_LIT_H: w_byte = {1'b0, r_cmd.flush_len};
            S_LIT_D: w_byte = r_rd_data;
            default: w_byte = '0;
        endcase
        w_byte_v = (r_state == S_RUN_H) || (r_state == S_RUN_B) ||
                   (r_state == S_LIT_H) || (r_state == S_LIT_D);
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_pk_data    = r_pk_data;
        n_pk_cnt     = r_pk_cnt;
        n_carry_data = r_carry_data;
        n_carry_cnt  = r_carry_cnt;
        n_carry_v    = r_carry_v;
        n_nres       = r_nres;
        n_lidx       = r_lidx;
        w_adv        = 1'b0;
        w_rd_en      = 1'b0;
        w_rd_addr    = '0;
        o_word_valid = 1'b0;
        o_word       = '0;

        // byte packer: a full word is held until the next byte shows it is not the last
        if (w_byte_v) begin
            if (r_pk_cnt != PK_FULL) begin
                n_pk_data[{r_pk_cnt[2:0], 3'b000} +: 8] = w_byte;
                n_pk_cnt = r_pk_cnt + 1'b1;
                w_adv    = 1'b1;
            end else if (r_nres == LIMIT) begin
                // beyond what the carry word can hold
                w_adv = 1'b1;
            end else if (r_carry_v) begin
                o_word_valid       = 1'b1;
                o_word.packed_bytes = r_carry_data;
                o_word.byte_count  = r_carry_cnt;
                o_word.block_done  = 1'b1;
                if (i_word_ready) begin
                    n_carry_v = 1'b0;
                    n_nres    = r_nres + 1'b1;
                end
            end else begin
                o_word_valid        = 1'b1;
                o_word.packed_bytes = r_pk_data;
                o_word.byte_count   = r_pk_cnt;
                o_word.last_of_run  = (r_nres == LIMIT_M1);
                if (i_word_ready) begin
                    n_nres    = r_nres + 1'b1;
                    n_pk_data = {{(WW - 8){1'b0}}, w_byte};
                    n_pk_cnt  = BW'(1);
                    w_adv     = 1'b1;
                end
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd = i_cmd;
                    if (i_cmd.run) begin
                        n_state = S_RUN_H;
                    end else if (i_cmd.flush) begin
                        n_state = S_LIT_H;
                    end else if (i_cmd.step_end && (r_carry_v || r_pk_cnt != '0)) begin
                        n_state = S_END;
                    end else if (i_cmd.step_end) begin
                        n_nres = '0;
                    end
                end
            end
            S_RUN_H: begin
                if (w_adv) begin
                    n_state = S_RUN_B;
                end
            end
            S_RUN_B: begin
                if (w_adv) begin
                    n_state = w_after_run;
                end
            end
            S_LIT_H: begin
                if (w_adv) begin
                    if (r_cmd.flush_len != '0) begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = '0;
                        n_lidx    = '0;
                        n_state   = S_LIT_D;
                    end else begin
                        n_state = w_after_lit;
                    end
                end
            end
            S_LIT_D: begin
                if (w_adv) begin
                    if (({1'b0, r_lidx} + 8'd1) < {1'b0, r_cmd.flush_len}) begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = r_lidx + 1'b1;
                        n_lidx    = r_lidx + 1'b1;
                    end else begin
                        n_state = w_after_lit;
                    end
                end
            end
            S_END: begin
                if (r_carry_v) begin
                    // leftover word of an overlong flush goes out first
                    o_word_valid        = 1'b1;
                    o_word.packed_bytes = r_carry_data;
                    o_word.byte_count   = r_carry_cnt;
                    o_word.last_of_run  = (r_pk_cnt == '0);
                    o_word.block_done   = 1'b1;
                    if (i_word_ready) begin
                        n_carry_v = 1'b0;
                        if (r_pk_cnt == '0) begin
                            n_nres  = '0;
                            n_state = S_IDLE;
                        end else begin
                            n_nres = r_nres + 1'b1;
                        end
                    end
                end else if (r_pk_cnt != '0) begin
                    if (r_nres != LIMIT) begin
                        o_word_valid        = 1'b1;
                        o_word.packed_bytes = r_pk_data;
                        o_word.byte_count   = r_pk_cnt;
                        o_word.last_of_run  = 1'b1;
                        o_word.block_done   = r_cmd.blk_end;
                        if (i_word_ready) begin
                            n_pk_data = '0;
                            n_pk_cnt  = '0;
                            n_nres    = '0;
                            n_state   = S_IDLE;
                        end
                    end else begin
                        n_carry_data = r_pk_data;
                        n_carry_cnt  = r_pk_cnt;
                        n_carry_v    = 1'b1;
                        n_pk_data    = '0;
                        n_pk_cnt     = '0;
                        n_nres       = '0;
                        n_state      = S_IDLE;
                    end
                end else begin
                    n_nres  = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pk_data <= '0;
            r_pk_cnt  <= '0;
            r_carry_v <= 1'b0;
            r_nres    <= '0;
        end else begin
            r_state   <= n_state;
            r_pk_data <= n_pk_data;
            r_pk_cnt  <= n_pk_cnt;
            r_carry_v <= n_carry_v;
            r_nres    <= n_nres;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_carry_data <= n_carry_data;
        r_carry_cnt  <= n_carry_cnt;
        r_lidx       <= n_lidx;
    end

    // literal store
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[i_cmd.idx[AW-1:0]] <= i_cmd.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr[AW-1:0]];
        end
    end

    a_counts_bounded : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pk_cnt <= PK_FULL) && (r_nres <= LIMIT))
        else $error("packer or word count out of range");

    a_word_size : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_word_valid |-> (o_word.byte_count != '0 && o_word.byte_count <= PK_FULL))
        else $error("output word with bad byte count");

    a_store_read_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIT_D) |-> (r_lidx < r_cmd.flush_len))
        else $error("literal read past the open literal");

endmodule

`default_nettype wire

>>> rtl/rle_byte_encoder.sv
// top level of the run-length byte encoder (packet headers: bit 7 marks a run, low bits hold the byte count)
//
//  channel   | handshake               | payload
//  ----------+-------------------------+--------------------------------------------------
//  input     | i_in_valid / o_in_ready | i_data_byte, i_block_end
//  output    | o_out_valid/i_out_ready | o_packed_bytes, o_byte_count, o_last_of_run,
//            |                         | o_block_done
//
//  one byte accepted per cycle while the command queue has room; a block-end byte holds
//  the input until its flush command is issued
//  back end: takes a command while idle, then handles each encoded byte in turn (one
//  literal store read or packer write each), and closes a step that produced words
//  reset clears the state registers, counters and queue pointers; the literal store is
//  not cleared and needs no sweep
//  the output queue absorbs word bursts, so a stalled sink backs up into the input only
//  once both queues are full
`default_nettype none

module rle_byte_encoder #(
    parameter int unsigned MAX_PACKET = 127,
    parameter int unsigned CMD_DEPTH  = 4,
    parameter int unsigned OUT_DEPTH  = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_block_end,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [63:0]      o_packed_bytes,
    output logic [3:0]       o_byte_count,
    output logic             o_last_of_run,
    output logic             o_block_done
);

    localparam int unsigned CMD_W  = $bits(rbe_pkg::t_cmd);
    localparam int unsigned WORD_W = $bits(rbe_pkg::t_word);

    rbe_pkg::t_cmd  w_fe_cmd;
    logic           w_fe_valid;
    logic           w_fe_ready;
    logic [CMD_W-1:0] w_q_cmd;
    rbe_pkg::t_cmd  w_be_cmd;
    logic           w_be_valid;
    logic           w_be_ready;
    rbe_pkg::t_word w_word;
    logic           w_word_valid;
    logic           w_word_ready;
    logic [WORD_W-1:0] w_q_word;
    rbe_pkg::t_word w_out;

    rbe_front #(
        .MAX_PACKET (MAX_PACKET)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_block_end (i_block_end),
        .o_cmd_valid (w_fe_valid),
        .i_cmd_ready (w_fe_ready),
        .o_cmd       (w_fe_cmd)
    );

    rbe_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_fe_valid),
        .o_wr_ready (w_fe_ready),
        .i_wr_data  (w_fe_cmd),
        .o_rd_valid (w_be_valid),
        .i_rd_ready (w_be_ready),
        .o_rd_data  (w_q_cmd)
    );

    assign w_be_cmd = rbe_pkg::t_cmd'(w_q_cmd);

    rbe_back #(
        .MAX_PACKET (MAX_PACKET)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_be_valid),
        .o_cmd_ready  (w_be_ready),
        .i_cmd        (w_be_cmd),
        .o_word_valid (w_word_valid),
        .i_word_ready (w_word_ready),
        .o_word       (w_word)
    );

    rbe_fifo #(
        .WIDTH (WORD_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_word_valid),
        .o_wr_ready (w_word_ready),
        .i_wr_data  (w_word),
        .o_rd_valid (o_out_valid),
        .i_rd_ready (i_out_ready),
        .o_rd_data  (w_q_word)
    );

    assign w_out          = rbe_pkg::t_word'(w_q_word);
    assign o_packed_bytes = w_out.packed_bytes;
    assign o_byte_count   = w_out.byte_count;
    assign o_last_of_run  = w_out.last_of_run;
    assign o_block_done   = w_out.block_done;

endmodule

`default_nettype wire
